### sv/ill_pkg.sv
`default_nettype none

package ill_pkg;

	localparam int CHAR_W  = 16;
	localparam int VALUE_W = 64;
	localparam int TYPE_W  = 3;
	localparam int SFX_LEN = 3;
	localparam int SFX_CNT_W = 3;
	localparam int SFX_IDX_W = 2;
	localparam int OUT_DATA_W = 72;

	// literal types
	localparam logic [TYPE_W-1:0] TYPE_INT16  = 3'd0;
	localparam logic [TYPE_W-1:0] TYPE_INT32  = 3'd1;
	localparam logic [TYPE_W-1:0] TYPE_INT64  = 3'd2;
	localparam logic [TYPE_W-1:0] TYPE_UINT16 = 3'd3;
	localparam logic [TYPE_W-1:0] TYPE_UINT32 = 3'd4;
	localparam logic [TYPE_W-1:0] TYPE_UINT64 = 3'd5;

	// character codes
	localparam logic [CHAR_W-1:0] CH_0  = 16'h0030;
	localparam logic [CHAR_W-1:0] CH_9  = 16'h0039;
	localparam logic [CHAR_W-1:0] CH_UA = 16'h0041;
	localparam logic [CHAR_W-1:0] CH_UB = 16'h0042;
	localparam logic [CHAR_W-1:0] CH_UF = 16'h0046;
	localparam logic [CHAR_W-1:0] CH_UX = 16'h0058;
	localparam logic [CHAR_W-1:0] CH_LA = 16'h0061;
	localparam logic [CHAR_W-1:0] CH_LB = 16'h0062;
	localparam logic [CHAR_W-1:0] CH_LF = 16'h0066;
	localparam logic [CHAR_W-1:0] CH_LX = 16'h0078;
	localparam logic [CHAR_W-1:0] CH_1  = 16'h0031;
	localparam logic [CHAR_W-1:0] CH_2  = 16'h0032;
	localparam logic [CHAR_W-1:0] CH_3  = 16'h0033;
	localparam logic [CHAR_W-1:0] CH_4  = 16'h0034;
	localparam logic [CHAR_W-1:0] CH_6  = 16'h0036;
	localparam logic [CHAR_W-1:0] CH_LS = 16'h0073;
	localparam logic [CHAR_W-1:0] CH_LU = 16'h0075;

	// accepted suffixes, index equals the literal type
	localparam logic [CHAR_W-1:0] SFX_FORMS [6][SFX_LEN] = '{
		'{CH_LS, CH_1, CH_6}, '{CH_LS, CH_3, CH_2}, '{CH_LS, CH_6, CH_4},
		'{CH_LU, CH_1, CH_6}, '{CH_LU, CH_3, CH_2}, '{CH_LU, CH_6, CH_4}
	};

	typedef enum logic [2:0] {
		PH_START,
		PH_ZERO,
		PH_DEC,
		PH_BIN,
		PH_HEX,
		PH_OCT,
		PH_SUFFIX
	} phase_t;

	typedef struct packed {
		phase_t               phase;
		logic [VALUE_W-1:0]   acc;
		logic                 ovf;
		logic [SFX_CNT_W-1:0] sfx_cnt;
	} lex_state_t;

	typedef struct packed {
		logic                 en;
		logic [SFX_IDX_W-1:0] idx;
	} sfx_wr_t;

endpackage

`default_nettype wire

### sv/ill_step.sv
`default_nettype none

module ill_step (
	input  wire ill_pkg::lex_state_t      cur,
	input  wire logic [ill_pkg::CHAR_W-1:0] ch,
	output ill_pkg::lex_state_t           nxt,
	output ill_pkg::sfx_wr_t              sfx_wr
);
	import ill_pkg::*;

	logic       do_radix;
	logic [4:0] radix;
	logic [4:0] dval;
	logic       is_digit;
	logic [VALUE_W+3:0] prod;
	logic [VALUE_W+3:0] sum;

	// digit decode for the current radix
	always_comb begin
		dval = '0;
		is_digit = 1'b0;
		if (ch >= CH_0 && ch <= CH_9) begin
			dval = 5'(ch - CH_0);
			is_digit = 1'b1;
		end else if (ch >= CH_LA && ch <= CH_LF) begin
			dval = 5'(ch - CH_LA + 16'd10);
			is_digit = 1'b1;
		end else if (ch >= CH_UA && ch <= CH_UF) begin
			dval = 5'(ch - CH_UA + 16'd10);
			is_digit = 1'b1;
		end
		if (dval >= radix) begin
			is_digit = 1'b0;
		end
	end

	// multiply by radix as shifts, overflow when the sum passes 64 bits
	always_comb begin
		case (radix)
			5'd2:    prod = {3'b0, cur.acc, 1'b0};
			5'd8:    prod = {1'b0, cur.acc, 3'b0};
			5'd16:   prod = {cur.acc, 4'b0};
			default: prod = {1'b0, cur.acc, 3'b0} + {3'b0, cur.acc, 1'b0};
		endcase
		sum = prod + (VALUE_W+4)'(dval);
	end

	always_comb begin
		do_radix = 1'b0;
		radix = 5'd10;
		nxt = cur;
		unique case (cur.phase)
			PH_START: begin
				if (ch == CH_0) begin
					nxt.phase = PH_ZERO;
				end else begin
					nxt.phase = PH_DEC;
					do_radix = 1'b1;
				end
			end
			PH_ZERO: begin
				if (ch == CH_LB || ch == CH_UB) begin
					nxt.phase = PH_BIN;
				end else if (ch == CH_LX || ch == CH_UX) begin
					nxt.phase = PH_HEX;
				end else begin
					nxt.phase = PH_OCT;
					radix = 5'd8;
					do_radix = 1'b1;
				end
			end
			PH_DEC: do_radix = 1'b1;
			PH_BIN: begin
				radix = 5'd2;
				do_radix = 1'b1;
			end
			PH_HEX: begin
				radix = 5'd16;
				do_radix = 1'b1;
			end
			PH_OCT: begin
				radix = 5'd8;
				do_radix = 1'b1;
			end
			default: ;
		endcase

		sfx_wr.en = 1'b0;
		sfx_wr.idx = cur.sfx_cnt[SFX_IDX_W-1:0];
		if (do_radix && is_digit) begin
			if (!cur.ovf) begin
				if (|sum[VALUE_W+3:VALUE_W]) begin
					nxt.ovf = 1'b1;
				end else begin
					nxt.acc = sum[VALUE_W-1:0];
				end
			end
		end else if (do_radix || cur.phase == PH_SUFFIX) begin
			// character belongs to the suffix
			nxt.phase = PH_SUFFIX;
			sfx_wr.en = (cur.sfx_cnt < SFX_CNT_W'(SFX_LEN));
			if (cur.sfx_cnt < SFX_CNT_W'(SFX_LEN + 1)) begin
				nxt.sfx_cnt = cur.sfx_cnt + 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

### sv/ill_classify.sv
`default_nettype none

module ill_classify (
	input  wire ill_pkg::lex_state_t        st,
	input  wire logic [ill_pkg::CHAR_W-1:0] sfx [ill_pkg::SFX_LEN],
	output logic [ill_pkg::VALUE_W-1:0]     literal_value,
	output logic [ill_pkg::TYPE_W-1:0]      literal_type,
	output logic                            too_large,
	output logic                            bad_suffix
);
	import ill_pkg::*;

	logic [5:0] hit;

	always_comb begin
		for (int k = 0; k < 6; k++) begin
			hit[k] = (sfx[0] == SFX_FORMS[k][0]) && (sfx[1] == SFX_FORMS[k][1]) &&
				(sfx[2] == SFX_FORMS[k][2]);
		end
	end

	always_comb begin
		literal_value = st.ovf ? '0 : st.acc;
		too_large = st.ovf;
		bad_suffix = 1'b0;
		literal_type = TYPE_INT16;
		if (st.sfx_cnt == '0) begin
			if (literal_value[VALUE_W-1:31] == '0) begin
				literal_type = TYPE_INT32;
			end else if (!literal_value[VALUE_W-1]) begin
				literal_type = TYPE_INT64;
			end else begin
				literal_type = TYPE_UINT64;
			end
		end else begin
			bad_suffix = 1'b1;
			if (st.sfx_cnt == SFX_CNT_W'(SFX_LEN)) begin
				for (int k = 5; k >= 0; k--) begin
					if (hit[k]) begin
						literal_type = TYPE_W'(k);
						bad_suffix = 1'b0;
					end
				end
			end
		end
	end

endmodule

`default_nettype wire

### sv/integer_literal_lexer.sv
// integer literal lexer
// input channel s_*: one character of a token per word, s_tdata holds the
// 16-bit code point, s_tlast marks the final character of the token.
// the token may start with 0b/0B (binary), 0x/0X (hex), 0 (octal) or a
// nonzero digit (decimal); trailing characters form a type suffix.
// output channel m_*: one word per token, carrying value, type and flags.
// a character is registered in the input stage when accepted and is then
// lexed into the lexer state; the result word for a token is registered as
// its last character is lexed, which waits while the result register is full.
// throughput: one character per cycle unless a last character waits, limited
// by the accumulate (shift-and-add by radix plus the digit) and overflow test.
// a stalled receiver holds the result word; the input register keeps
// taking characters of the next token until a second last character has
// to wait, then s_tready drops.
// reset clears the lexer state, the input stage flags and the result valid.
`default_nettype none

module integer_literal_lexer (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic s_tvalid,
	output logic      s_tready,
	input  wire logic [15:0] s_tdata, // char_code[15:0]
	input  wire logic s_tlast,        // last_char
	output logic      m_tvalid,
	input  wire logic m_tready,
	output logic [ill_pkg::OUT_DATA_W-1:0] m_tdata // literal_value[63:0],
	// literal_type[66:64], too_large[67], bad_suffix[68], zero fill [71:69]
);
	import ill_pkg::*;

	// input stage
	logic                valid_s1;
	logic [CHAR_W-1:0]   char_s1;
	logic                last_s1;

	// lexer state
	lex_state_t          state_q;
	lex_state_t          state_nxt;
	sfx_wr_t             sfx_wr;
	logic [CHAR_W-1:0]   sfx_q   [SFX_LEN];
	logic [CHAR_W-1:0]   sfx_nxt [SFX_LEN];

	// result
	logic [VALUE_W-1:0]  value_c;
	logic [TYPE_W-1:0]   type_c;
	logic                too_large_c;
	logic                bad_c;
	logic                out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;

	logic out_free;
	logic adv_s1;

	assign out_free = !out_valid_q || m_tready;
	// a final character may only retire when the result register is free
	assign adv_s1   = valid_s1 && (!last_s1 || out_free);
	assign s_tready = !valid_s1 || adv_s1;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	ill_step u_step (
		.cur    (state_q),
		.ch     (char_s1),
		.nxt    (state_nxt),
		.sfx_wr (sfx_wr)
	);

	// suffix characters as they stand after this character
	always_comb begin
		for (int i = 0; i < SFX_LEN; i++) begin
			sfx_nxt[i] = (sfx_wr.en && sfx_wr.idx == SFX_IDX_W'(i)) ? char_s1 : sfx_q[i];
		end
	end

	ill_classify u_classify (
		.st            (state_nxt),
		.sfx           (sfx_nxt),
		.literal_value (value_c),
		.literal_type  (type_c),
		.too_large     (too_large_c),
		.bad_suffix    (bad_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			last_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
			last_s1 <= s_tlast;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			char_s1 <= s_tdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{phase: PH_START, acc: '0, ovf: 1'b0, sfx_cnt: '0};
		end else if (adv_s1) begin
			if (last_s1) begin
				// token done, back to start for the next one
				state_q <= '{phase: PH_START, acc: '0, ovf: 1'b0, sfx_cnt: '0};
			end else begin
				state_q <= state_nxt;
			end
		end
	end

	// suffix store needs no reset: only read after three writes of this token
	always_ff @(posedge clk) begin
		if (adv_s1 && sfx_wr.en) begin
			sfx_q[sfx_wr.idx] <= char_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && last_s1) begin
			out_data_q <= {3'b0, bad_c, too_large_c, type_c, value_c};
		end
	end

endmodule

`default_nettype wire
